// ===== hw/rtl/gzpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gzpc_pkg
// Shared types, constants and helper functions for the grid zone pixel
// counter: configuration layout, the front-to-back operation record and the
// state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package gzpc_pkg;

    // Grid and position sizing.
    localparam int GRID_MAX_SIDE = 8;
    localparam int POSITION_BITS = 12;

    localparam int SIDE_BITS = (GRID_MAX_SIDE > 1) ? $clog2(GRID_MAX_SIDE) : 1;
    localparam int SIDE_W    = SIDE_BITS + 1;
    localparam int CELL_BITS = 2 * SIDE_BITS;
    localparam int NUM_CELLS = 1 << CELL_BITS;

    localparam int POS_W = POSITION_BITS;
    localparam int EXT_W = POSITION_BITS + 1;

    // Register field widths.
    localparam int CFG_W   = 13;
    localparam int GRID_W  = 4;
    localparam int PIXEL_W = 8;
    localparam int CMP_W   = (EXT_W + 1 > CFG_W) ? EXT_W + 1 : CFG_W;

    localparam logic [CMP_W-1:0] EXT_TOP = CMP_W'(1) << POSITION_BITS;

    // Result fields.
    localparam int OUT_IDX_W   = 3;
    localparam int COUNT_W     = 25;
    localparam int OUT_FIELD_W = 2 * OUT_IDX_W + 2 * COUNT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Register reset values.
    localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = CFG_W'(480);
    localparam logic [GRID_W-1:0]  RST_GRID_COLUMNS = GRID_W'(5);
    localparam logic [GRID_W-1:0]  RST_GRID_ROWS    = GRID_W'(5);
    localparam logic [CFG_W-1:0]   RST_CELL_WIDTH   = CFG_W'(128);
    localparam logic [CFG_W-1:0]   RST_CELL_HEIGHT  = CFG_W'(96);
    localparam logic [PIXEL_W-1:0] RST_MATCH_VALUE  = '0;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_GRID_COLUMNS = 3'd2,
        CFG_GRID_ROWS    = 3'd3,
        CFG_CELL_WIDTH   = 3'd4,
        CFG_CELL_HEIGHT  = 3'd5,
        CFG_MATCH_VALUE  = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [CFG_W-1:0]   frame_width;
        logic [CFG_W-1:0]   frame_height;
        logic [GRID_W-1:0]  grid_columns;
        logic [GRID_W-1:0]  grid_rows;
        logic [CFG_W-1:0]   cell_width;
        logic [CFG_W-1:0]   cell_height;
        logic [PIXEL_W-1:0] match_value;
    } cfg_t;

    // One classified pixel as handed from the front to the back.
    typedef struct packed {
        logic                 clear;   // frame start: drop counts first
        logic                 hit;     // pixel matches and lies inside the grid
        logic [CELL_BITS-1:0] idx;     // cell address, row in the upper bits
        logic                 report;  // last pixel of the frame
        logic [SIDE_W-1:0]    cols;
        logic [SIDE_W-1:0]    rows;
    } op_t;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_COL,
        RS_ROW
    } resync_state_t;

    typedef enum logic {
        BK_RUN,
        BK_REPORT
    } back_state_t;

    // Frame extent: zero acts as one, anything past the position range is capped.
    function automatic logic [EXT_W-1:0] clamp_extent(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide == '0)
            return EXT_W'(1);
        else if (wide > EXT_TOP)
            return EXT_W'(EXT_TOP);
        else
            return EXT_W'(wide);
    endfunction

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [GRID_W-1:0] v);
        if (32'(v) > GRID_MAX_SIDE)
            return SIDE_W'(GRID_MAX_SIDE);
        else
            return SIDE_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gzpc_ram.sv =====
// ----------------------------------------------------------------------------
// gzpc_ram
// Generic single-write, single-read RAM with a registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module gzpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gzpc_div.sv =====
// ----------------------------------------------------------------------------
// gzpc_div
// Restoring divider, one quotient bit per cycle. Gives a position divided by
// a cell size: the quotient capped at the grid side, and the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module gzpc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [gzpc_pkg::POS_W-1:0]    dividend,
    input  wire logic [gzpc_pkg::CFG_W-1:0]    divisor,
    output logic                               done,
    output logic [gzpc_pkg::SIDE_W-1:0]        quotient,
    output logic [gzpc_pkg::POS_W-1:0]         remainder
);

    import gzpc_pkg::*;

    localparam int CNT_W = $clog2(POS_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [POS_W-1:0]   dvd_reg, dvd_next;
    logic [CFG_W-1:0]   dvs_reg, dvs_next;
    logic [CFG_W-1:0]   rem_reg, rem_next;
    logic [POS_W-1:0]   quo_reg, quo_next;
    logic [CFG_W:0]     trial;
    logic               fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, dvd_reg[POS_W-1]};
        fits      = trial >= {1'b0, dvs_reg};

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CFG_W'(trial - {1'b0, dvs_reg}) : CFG_W'(trial);
            quo_next = {quo_reg[POS_W-2:0], fits};
            dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(POS_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done      = done_reg;
    assign quotient  = (quo_reg >= POS_W'(GRID_MAX_SIDE)) ? SIDE_W'(GRID_MAX_SIDE)
                                                         : SIDE_W'(quo_reg);
    assign remainder = POS_W'(rem_reg);

endmodule

`default_nettype wire

// ===== hw/rtl/gzpc_front.sv =====
// ----------------------------------------------------------------------------
// gzpc_front
// Accepts pixels, tracks the raster position and the cell it falls in, and
// turns each pixel into one operation for the back end. The cell is kept
// as a running quotient and remainder per axis; after a cell size change
// both are rebuilt with the divider before the next pixel is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gzpc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gzpc_pkg::PIXEL_W-1:0]   s_tdata,
    input  wire logic                           s_tuser,
    input  wire gzpc_pkg::cfg_t                 cfg,
    input  wire logic                           resync_req,
    input  wire logic                           q_full,
    output logic                                q_push,
    output gzpc_pkg::op_t                       q_op
);

    import gzpc_pkg::*;

    resync_state_t      rs_reg, rs_next;

    logic [POS_W-1:0]   col_pos_reg, col_pos_next;
    logic [POS_W-1:0]   row_pos_reg, row_pos_next;
    logic [POS_W-1:0]   col_rem_reg, col_rem_next;
    logic [POS_W-1:0]   row_rem_reg, row_rem_next;
    logic [SIDE_W-1:0]  cx_reg, cx_next;
    logic [SIDE_W-1:0]  cy_reg, cy_next;

    logic               div_start;
    logic [POS_W-1:0]   div_dividend;
    logic [CFG_W-1:0]   div_divisor;
    logic               div_done;
    logic [SIDE_W-1:0]  div_quotient;
    logic [POS_W-1:0]   div_remainder;
    logic               col_load;
    logic               row_load;

    logic               accept;
    logic [EXT_W-1:0]   width_c;
    logic [EXT_W-1:0]   height_c;
    logic [SIDE_W-1:0]  cols_c;
    logic [SIDE_W-1:0]  rows_c;
    logic [POS_W-1:0]   col0, row0, crem0, rrem0;
    logic [SIDE_W-1:0]  cx0, cy0;
    logic [EXT_W-1:0]   col_inc, row_inc, crem_inc, rrem_inc;
    logic               line_end;
    logic               frame_end;

    gzpc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    // Resync sequencer: next state.
    always_comb
    begin
        rs_next = rs_reg;
        if (resync_req)
        begin
            rs_next = RS_COL;
        end
        else
        begin
            unique case (rs_reg)
                RS_IDLE: rs_next = RS_IDLE;
                RS_COL:  if (div_done) rs_next = RS_ROW;
                RS_ROW:  if (div_done) rs_next = RS_IDLE;
                default: rs_next = RS_IDLE;
            endcase
        end
    end

    // Resync sequencer: outputs.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = col_pos_reg;
        div_divisor  = cfg.cell_width;
        col_load     = 1'b0;
        row_load     = 1'b0;
        priority if (resync_req)
        begin
            div_start = 1'b1;
        end
        else if (rs_reg == RS_COL && div_done)
        begin
            div_start    = 1'b1;
            div_dividend = row_pos_reg;
            div_divisor  = cfg.cell_height;
            col_load     = 1'b1;
        end
        else if (rs_reg == RS_ROW && div_done)
        begin
            row_load = 1'b1;
        end
        else
        begin
            row_load = 1'b0;
        end
    end

    assign s_tready = (rs_reg == RS_IDLE) && !resync_req && !q_full;
    assign accept   = s_tvalid && s_tready;

    // Pixel classification and position stepping.
    always_comb
    begin
        width_c  = clamp_extent(cfg.frame_width);
        height_c = clamp_extent(cfg.frame_height);
        cols_c   = clamp_side(cfg.grid_columns);
        rows_c   = clamp_side(cfg.grid_rows);

        col0  = s_tuser ? '0 : col_pos_reg;
        row0  = s_tuser ? '0 : row_pos_reg;
        crem0 = s_tuser ? '0 : col_rem_reg;
        rrem0 = s_tuser ? '0 : row_rem_reg;
        cx0   = s_tuser ? '0 : cx_reg;
        cy0   = s_tuser ? '0 : cy_reg;

        col_inc  = EXT_W'(col0) + 1'b1;
        row_inc  = EXT_W'(row0) + 1'b1;
        crem_inc = EXT_W'(crem0) + 1'b1;
        rrem_inc = EXT_W'(rrem0) + 1'b1;

        line_end  = col_inc >= width_c;
        frame_end = line_end && (row_inc >= height_c);

        q_op.clear  = s_tuser;
        q_op.hit    = (s_tdata == cfg.match_value) && (cfg.cell_width != '0)
                      && (cfg.cell_height != '0) && (cx0 < cols_c) && (cy0 < rows_c);
        q_op.idx    = {cy0[SIDE_BITS-1:0], cx0[SIDE_BITS-1:0]};
        q_op.report = frame_end;
        q_op.cols   = cols_c;
        q_op.rows   = rows_c;
        q_push      = accept;

        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        col_rem_next = col_rem_reg;
        row_rem_next = row_rem_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;

        if (col_load)
        begin
            cx_next      = div_quotient;
            col_rem_next = div_remainder;
        end
        if (row_load)
        begin
            cy_next      = div_quotient;
            row_rem_next = div_remainder;
        end

        if (accept)
        begin
            if (line_end)
            begin
                col_pos_next = '0;
                col_rem_next = '0;
                cx_next      = '0;
                if (frame_end)
                begin
                    row_pos_next = '0;
                    row_rem_next = '0;
                    cy_next      = '0;
                end
                else
                begin
                    row_pos_next = POS_W'(row_inc);
                    if (CMP_W'(rrem_inc) == CMP_W'(cfg.cell_height))
                    begin
                        row_rem_next = '0;
                        cy_next = (cy0 >= SIDE_W'(GRID_MAX_SIDE)) ? cy0 : cy0 + 1'b1;
                    end
                    else
                    begin
                        row_rem_next = POS_W'(rrem_inc);
                        cy_next      = cy0;
                    end
                end
            end
            else
            begin
                col_pos_next = POS_W'(col_inc);
                row_pos_next = row0;
                row_rem_next = rrem0;
                cy_next      = cy0;
                if (CMP_W'(crem_inc) == CMP_W'(cfg.cell_width))
                begin
                    col_rem_next = '0;
                    cx_next = (cx0 >= SIDE_W'(GRID_MAX_SIDE)) ? cx0 : cx0 + 1'b1;
                end
                else
                begin
                    col_rem_next = POS_W'(crem_inc);
                    cx_next      = cx0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg      <= RS_IDLE;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            col_rem_reg <= '0;
            row_rem_reg <= '0;
            cx_reg      <= '0;
            cy_reg      <= '0;
        end
        else
        begin
            rs_reg      <= rs_next;
            col_pos_reg <= col_pos_next;
            row_pos_reg <= row_pos_next;
            col_rem_reg <= col_rem_next;
            row_rem_reg <= row_rem_next;
            cx_reg      <= cx_next;
            cy_reg      <= cy_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gzpc_queue.sv =====
// ----------------------------------------------------------------------------
// gzpc_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module gzpc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire gzpc_pkg::op_t    op_in,
    output logic                  full,
    input  wire logic             pop,
    output gzpc_pkg::op_t         op_out,
    output logic                  empty
);

    import gzpc_pkg::*;

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full   = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign empty  = count_reg == '0;
    assign op_out = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(32'(wr_ptr_reg) + 1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(32'(rd_ptr_reg) + 1) : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gzpc_back.sv =====
// ----------------------------------------------------------------------------
// gzpc_back
// Carries out the operations: read-modify-write of the cell counts in RAM,
// the running largest count, and the end-of-frame report sweep that feeds
// the output register. A valid bit per cell stands in for clearing the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module gzpc_back (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                q_empty,
    input  wire gzpc_pkg::op_t                       q_op,
    output logic                                     q_pop,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [gzpc_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                     m_tlast
);

    import gzpc_pkg::*;

    back_state_t            state_reg, state_next;

    // Update stage: the operation whose count is arriving from RAM.
    logic                   b_valid_reg;
    op_t                    b_op_reg;

    // Last write, for a read that raced it at the same edge.
    logic                   lw_valid_reg, lw_valid_next;
    logic [CELL_BITS-1:0]   lw_idx_reg;
    logic [COUNT_W-1:0]     lw_cnt_reg;

    logic [NUM_CELLS-1:0]   valid_reg, valid_next;
    logic [COUNT_W-1:0]     largest_reg, largest_next;

    // Report sweep.
    logic [SIDE_BITS-1:0]   rep_r_reg, rep_c_reg;
    logic [SIDE_W-1:0]      rep_cols_reg, rep_rows_reg;
    logic                   issued_all_reg;
    logic                   rd_pend_reg;
    logic [SIDE_BITS-1:0]   pend_r_reg, pend_c_reg;
    logic                   pend_last_reg;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_IDX_W-1:0]   out_col_reg, out_row_reg;
    logic [COUNT_W-1:0]     out_cnt_reg, out_big_reg;
    logic                   out_last_reg;

    logic [CELL_BITS-1:0]   raddr;
    logic [COUNT_W-1:0]     rdata;
    logic                   issue;
    logic                   rep_last;
    logic                   hit_wr;
    logic                   report_begin;
    logic                   report_empty;
    logic                   report_done;
    logic [COUNT_W-1:0]     old_cnt;
    logic [COUNT_W-1:0]     new_cnt;
    logic [COUNT_W-1:0]     largest_base;
    logic [COUNT_W-1:0]     rep_cnt;

    gzpc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_CELLS)
    ) u_count_ram (
        .clk   (clk),
        .we    (hit_wr),
        .waddr (b_op_reg.idx),
        .wdata (new_cnt),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign hit_wr       = b_valid_reg && b_op_reg.hit;
    assign report_begin = b_valid_reg && b_op_reg.report
                          && (b_op_reg.cols != '0) && (b_op_reg.rows != '0);
    assign report_empty = b_valid_reg && b_op_reg.report
                          && ((b_op_reg.cols == '0) || (b_op_reg.rows == '0));
    assign report_done  = rd_pend_reg && pend_last_reg;
    assign rep_last     = (SIDE_W'(rep_r_reg) + 1'b1 == rep_rows_reg)
                          && (SIDE_W'(rep_c_reg) + 1'b1 == rep_cols_reg);

    // State machine: next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:    if (report_begin) state_next = BK_REPORT;
            BK_REPORT: if (report_done) state_next = BK_RUN;
            default:   state_next = BK_RUN;
        endcase
    end

    // State machine: outputs. No operation follows a report into the update
    // stage until the sweep is over.
    always_comb
    begin
        q_pop = 1'b0;
        issue = 1'b0;
        raddr = q_op.idx;
        unique case (state_reg)
            BK_RUN:
            begin
                q_pop = !q_empty && !(b_valid_reg && b_op_reg.report);
            end
            BK_REPORT:
            begin
                raddr = {rep_r_reg, rep_c_reg};
                issue = !rd_pend_reg && !issued_all_reg && (!out_valid_reg || m_tready);
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // Count update and frame bookkeeping.
    always_comb
    begin
        if (b_op_reg.clear)
            old_cnt = '0;
        else if (lw_valid_reg && (lw_idx_reg == b_op_reg.idx))
            old_cnt = lw_cnt_reg;
        else if (valid_reg[b_op_reg.idx])
            old_cnt = rdata;
        else
            old_cnt = '0;

        new_cnt      = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;
        largest_base = (b_valid_reg && b_op_reg.clear) ? '0 : largest_reg;
        largest_next = largest_base;
        if (hit_wr && (new_cnt > largest_base))
            largest_next = new_cnt;

        valid_next = valid_reg;
        if (b_valid_reg && b_op_reg.clear)
            valid_next = '0;
        if (hit_wr)
            valid_next[b_op_reg.idx] = 1'b1;

        // The frame's counts are dropped once they have been reported.
        if (report_empty || report_done)
        begin
            valid_next   = '0;
            largest_next = '0;
        end

        lw_valid_next = hit_wr && !b_op_reg.report;

        rep_cnt = valid_reg[{pend_r_reg, pend_c_reg}] ? rdata : '0;

        out_valid_next = out_valid_reg && !m_tready;
        if (rd_pend_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_RUN;
            b_valid_reg    <= 1'b0;
            lw_valid_reg   <= 1'b0;
            valid_reg      <= '0;
            largest_reg    <= '0;
            rep_r_reg      <= '0;
            rep_c_reg      <= '0;
            rep_cols_reg   <= '0;
            rep_rows_reg   <= '0;
            issued_all_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            b_valid_reg   <= q_pop;
            lw_valid_reg  <= lw_valid_next;
            valid_reg     <= valid_next;
            largest_reg   <= largest_next;
            rd_pend_reg   <= issue;
            out_valid_reg <= out_valid_next;

            if (report_begin)
            begin
                rep_r_reg      <= '0;
                rep_c_reg      <= '0;
                rep_cols_reg   <= b_op_reg.cols;
                rep_rows_reg   <= b_op_reg.rows;
                issued_all_reg <= 1'b0;
            end
            else if (issue)
            begin
                if (rep_last)
                begin
                    issued_all_reg <= 1'b1;
                end
                else if (SIDE_W'(rep_c_reg) + 1'b1 == rep_cols_reg)
                begin
                    rep_c_reg <= '0;
                    rep_r_reg <= rep_r_reg + 1'b1;
                end
                else
                begin
                    rep_c_reg <= rep_c_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            b_op_reg <= q_op;
        if (hit_wr)
        begin
            lw_idx_reg <= b_op_reg.idx;
            lw_cnt_reg <= new_cnt;
        end
        if (issue)
        begin
            pend_r_reg    <= rep_r_reg;
            pend_c_reg    <= rep_c_reg;
            pend_last_reg <= rep_last;
        end
        if (rd_pend_reg)
        begin
            out_col_reg  <= OUT_IDX_W'(pend_c_reg);
            out_row_reg  <= OUT_IDX_W'(pend_r_reg);
            out_cnt_reg  <= rep_cnt;
            out_big_reg  <= largest_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_TDATA_W'({out_big_reg, out_cnt_reg, out_row_reg, out_col_reg});

    // A report read only lands in an empty output register.
    a_pend_lands_free: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("report data arrived while the output register was occupied");

    a_pend_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> state_reg == BK_REPORT)
        else $error("report read outstanding outside the report sweep");

    a_report_isolated: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_op_reg.report) |=> !b_valid_reg)
        else $error("an operation entered the update stage right behind a report");

    a_counts_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        report_done |=> (valid_reg == '0) && (largest_reg == '0))
        else $error("counts survived the end of the report sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/grid_zone_pixel_count.sv =====
// ----------------------------------------------------------------------------
// grid_zone_pixel_count
// Counts matching mask pixels per cell of a configurable grid and reports
// every cell's count, with the frame's largest count, after the last pixel.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while no cell size rebuild is in progress and
//   the operation queue (four entries) has room; the queue fills when the back
//   end is held in a report sweep.
// Reporting: the last pixel's operation passes the queue and the update stage;
//   the sweep then reads each cell's count into the output register, one read
//   in flight at a time, paced by the registered read of the count RAM.
// A write to cell_width or cell_height holds off input while the divider rebuilds
//   the cell indexes, first the column index, then the row index.
// Reset: all counts, positions and configuration registers take their reset values at once;
//   there is no clearing pass, so the block accepts pixels right after reset.
`default_nettype none

module grid_zone_pixel_count (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Pixel stream in.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [gzpc_pkg::PIXEL_W-1:0]        s_tdata,   // [7:0] pixel_value
    input  wire logic                                s_tuser,   // [0] frame_start

    // Cell report stream out.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [2:0] cell_column, [5:3] cell_row, [30:6] match_count, [55:31] largest_count
    output logic [gzpc_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                     m_tlast,   // last_cell

    // Register write port.
    input  wire logic                                cfg_wr_en,
    input  wire logic [gzpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gzpc_pkg::CFG_W-1:0]          cfg_wdata
);

    import gzpc_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    logic   resync_reg, resync_next;

    logic   q_push;
    op_t    q_in;
    logic   q_full;
    logic   q_pop;
    op_t    q_out;
    logic   q_empty;

    // Register writes. A new cell size invalidates the front's running cell
    // indexes; the rebuild starts the cycle after the write, once the new
    // value is in its register.
    always_comb
    begin
        cfg_next    = cfg_reg;
        resync_next = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_wdata;
                CFG_FRAME_HEIGHT: cfg_next.frame_height = cfg_wdata;
                CFG_GRID_COLUMNS: cfg_next.grid_columns = GRID_W'(cfg_wdata);
                CFG_GRID_ROWS:    cfg_next.grid_rows    = GRID_W'(cfg_wdata);
                CFG_CELL_WIDTH:
                begin
                    cfg_next.cell_width = cfg_wdata;
                    resync_next         = 1'b1;
                end
                CFG_CELL_HEIGHT:
                begin
                    cfg_next.cell_height = cfg_wdata;
                    resync_next          = 1'b1;
                end
                CFG_MATCH_VALUE:  cfg_next.match_value  = PIXEL_W'(cfg_wdata);
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.grid_columns <= RST_GRID_COLUMNS;
            cfg_reg.grid_rows    <= RST_GRID_ROWS;
            cfg_reg.cell_width   <= RST_CELL_WIDTH;
            cfg_reg.cell_height  <= RST_CELL_HEIGHT;
            cfg_reg.match_value  <= RST_MATCH_VALUE;
            resync_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            resync_reg <= resync_next;
        end
    end

    // Front: position tracking and pixel classification.
    gzpc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .cfg        (cfg_reg),
        .resync_req (resync_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_op       (q_in)
    );

    // Decoupling queue: lets pixels keep flowing while the back end is busy
    // with a report or the output side stalls.
    gzpc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .op_in  (q_in),
        .full   (q_full),
        .pop    (q_pop),
        .op_out (q_out),
        .empty  (q_empty)
    );

    // Back: count RAM, largest count and the report sweep.
    gzpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_op     (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_grid_zone_pixel_count.sv =====
// ----------------------------------------------------------------------------
// tb_grid_zone_pixel_count
// Self-checking testbench for the grid zone pixel counter. Mask frames are
// streamed in with random bursts and gaps, and an internal tally of per-cell
// match counts predicts every cell report. Each report is checked field by
// field, with random receiver stalls and one long hold-off that backs up the
// input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grid_zone_pixel_count;

    import gzpc_pkg::*;

    // Run length limits: clock cycles, but RANDOM_ITEMS counts pixels.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 24;

    // One expected or observed cell report.
    typedef struct {
        bit [OUT_IDX_W-1:0] column;
        bit [OUT_IDX_W-1:0] row;
        bit [COUNT_W-1:0]   count;
        bit [COUNT_W-1:0]   largest;
        bit                 last;
    } cell_report_t;

    // ------------------------------------------------------------------------
    // Per-cell tally of matching pixels and the queue of cell reports that
    // the block still owes. It keeps its own copy of the registers, the
    // raster position and the counts.
    // ------------------------------------------------------------------------
    class cell_tally_board;
        bit [CFG_W-1:0]   frame_w;
        bit [CFG_W-1:0]   frame_h;
        bit [GRID_W-1:0]  grid_c;
        bit [GRID_W-1:0]  grid_r;
        bit [CFG_W-1:0]   cell_w;
        bit [CFG_W-1:0]   cell_h;
        bit [PIXEL_W-1:0] match_reg;

        bit [COUNT_W-1:0] counts[NUM_CELLS];
        bit [COUNT_W-1:0] largest;
        bit [POS_W-1:0]   col_pos;
        bit [POS_W-1:0]   row_pos;

        cell_report_t expected_reports[$];
        int failures;

        function new();
            frame_w   = RST_FRAME_WIDTH;
            frame_h   = RST_FRAME_HEIGHT;
            grid_c    = RST_GRID_COLUMNS;
            grid_r    = RST_GRID_ROWS;
            cell_w    = RST_CELL_WIDTH;
            cell_h    = RST_CELL_HEIGHT;
            match_reg = RST_MATCH_VALUE;
            failures  = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            foreach (counts[i])
                counts[i] = '0;
            largest = '0;
            col_pos = '0;
            row_pos = '0;
        endfunction

        // A zero extent acts as one line or pixel; anything past the
        // position range is capped at the range.
        function int extent(bit [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            else if (int'(v) > (1 << POSITION_BITS))
                return 1 << POSITION_BITS;
            else
                return int'(v);
        endfunction

        function int side(bit [GRID_W-1:0] v);
            return (int'(v) > GRID_MAX_SIDE) ? GRID_MAX_SIDE : int'(v);
        endfunction

        function int pixels_per_frame();
            return extent(frame_w) * extent(frame_h);
        endfunction

        function void write_reg(cfg_index_t idx, bit [CFG_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:  frame_w   = value;
                CFG_FRAME_HEIGHT: frame_h   = value;
                CFG_GRID_COLUMNS: grid_c    = value[GRID_W-1:0];
                CFG_GRID_ROWS:    grid_r    = value[GRID_W-1:0];
                CFG_CELL_WIDTH:   cell_w    = value;
                CFG_CELL_HEIGHT:  cell_h    = value;
                CFG_MATCH_VALUE:  match_reg = value[PIXEL_W-1:0];
                default: ;
            endcase
        endfunction

        // Accounts for one accepted pixel and queues the cell reports that
        // it triggers when it closes the frame.
        function void note_pixel(bit [PIXEL_W-1:0] pixel, bit start);
            int width;
            int height;
            int cols;
            int rows;
            int cx;
            int cy;
            int idx;
            int total;
            int n;
            cell_report_t rep;

            width  = extent(frame_w);
            height = extent(frame_h);
            cols   = side(grid_c);
            rows   = side(grid_r);

            if (start)
                clear_frame();

            if (pixel == match_reg && cell_w != 0 && cell_h != 0) begin
                cx = int'(col_pos) / int'(cell_w);
                cy = int'(row_pos) / int'(cell_h);
                if (cx < cols && cy < rows) begin
                    idx = cy * GRID_MAX_SIDE + cx;
                    if (counts[idx] != '1)
                        counts[idx] = counts[idx] + 1'b1;
                    if (counts[idx] > largest)
                        largest = counts[idx];
                end
            end

            if (int'(col_pos) + 1 >= width) begin
                col_pos = '0;
                if (int'(row_pos) + 1 >= height) begin
                    total = cols * rows;
                    n = 0;
                    for (int r = 0; r < rows; r++) begin
                        for (int c = 0; c < cols; c++) begin
                            rep.column  = c[OUT_IDX_W-1:0];
                            rep.row     = r[OUT_IDX_W-1:0];
                            rep.count   = counts[r * GRID_MAX_SIDE + c];
                            rep.largest = largest;
                            rep.last    = (n + 1 == total);
                            expected_reports.insert(expected_reports.size(), rep);
                            n++;
                        end
                    end
                    clear_frame();
                end
                else begin
                    row_pos = row_pos + 1'b1;
                end
            end
            else begin
                col_pos = col_pos + 1'b1;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                failures++;
            end
        endfunction

        // Checks one accepted report against the oldest one still owed.
        function void check_report(bit [OUT_TDATA_W-1:0] data, bit last);
            cell_report_t want;
            cell_report_t got;

            got.column  = data[2:0];
            got.row     = data[5:3];
            got.count   = data[30:6];
            got.largest = data[55:31];
            got.last    = last;

            if (expected_reports.size() == 0) begin
                $error("cell report with none expected: column %0d row %0d count %0d",
                       got.column, got.row, got.count);
                failures++;
            end
            else begin
                want = expected_reports.pop_front();
                compare_field("cell_column", want.column, got.column);
                compare_field("cell_row", want.row, got.row);
                compare_field("match_count", want.count, got.count);
                compare_field("largest_count", want.largest, got.largest);
                compare_field("last_cell", want.last, got.last);
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its connections.
    // ------------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    cell_tally_board board = new();

    // Sender pacing and receiver hold-off controls.
    int burst_left  = 0;
    bit hold_armed  = 0;
    int cycle_count = 0;

    grid_zone_pixel_count DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Every report transaction is checked at the rising edge where it is
    // accepted. Outputs are read before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_report(m_tdata, m_tlast);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** grid_zone_pixel_count: FAILED **");
            $finish;
        end
    end

    // Receiver: picks a random stall pattern for each run of random length. When
    // the main sequence arms the hold-off, the first pending report is left
    // waiting for a long stretch while the sender keeps pushing pixels, so
    // the operation queue fills and the block drops s_tready.
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_armed && m_tvalid) begin
                hold_armed = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
                0:       m_tready = 1'b1;
                1:       m_tready = ($urandom_range(0, 3) != 0);
                default: m_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks. All of them start and end at a falling edge, where the
    // inputs change.
    // ------------------------------------------------------------------------

    // Offers one pixel and holds it until a transaction takes it. s_tvalid is
    // left high so that the next pixel can follow with no gap.
    task automatic send_pixel(bit [PIXEL_W-1:0] pixel, bit start);
        s_tdata  = pixel;
        s_tuser  = start;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_pixel(pixel, start);
        @(negedge clk);
    endtask

    // Bursts of random length separated by short gaps. Now and then a long
    // burst runs with no gap at all.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            gap = $urandom_range(1, 5);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Sends a run of pixels, match_pct percent of them equal to the match
    // value. With noisy set, a stray frame start may land mid-run.
    task automatic send_frame(int pixels, int match_pct, bit mark_start, bit noisy);
        bit [PIXEL_W-1:0] pix;
        bit               start;
        for (int i = 0; i < pixels; i++) begin
            pix = ($urandom_range(0, 99) < match_pct) ? board.match_reg
                                                      : PIXEL_W'($urandom_range(0, 255));
            start = (i == 0 && mark_start) || (noisy && $urandom_range(0, 29) == 0);
            send_pixel(pix, start);
            pace_sender();
        end
    endtask

    // Waits until every owed report has arrived, then long enough for a
    // frame end that owes no report to finish inside the block.
    task automatic settle();
        s_tvalid = 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_reg(cfg_index_t idx, int value);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = CFG_W'(value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        board.write_reg(idx, CFG_W'(value));
    endtask

    task automatic configure(int width, int height, int cols, int rows,
                             int cw, int ch, int match_val);
        settle();
        program_reg(CFG_FRAME_WIDTH, width);
        program_reg(CFG_FRAME_HEIGHT, height);
        program_reg(CFG_GRID_COLUMNS, cols);
        program_reg(CFG_GRID_ROWS, rows);
        program_reg(CFG_CELL_WIDTH, cw);
        program_reg(CFG_CELL_HEIGHT, ch);
        program_reg(CFG_MATCH_VALUE, match_val);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        int random_items;
        int width;
        int height;
        int cols;
        int rows;
        int cw;
        int ch;
        int frames;
        int pixels;
        int pct;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A 3x3 frame on a 2x2 grid of single pixels, so the right column
        // and bottom line fall outside the grid. Both pixel extremes appear.
        // The middle run is cut short by a new frame start, which must drop
        // its counts.
        configure(3, 3, 2, 2, 1, 1, 255);
        for (int i = 0; i < 9; i++) begin
            send_pixel((i % 3 == 1) ? 8'd0 : 8'd255, i == 0);
            pace_sender();
        end
        for (int i = 0; i < 3; i++) begin
            send_pixel(8'd255, i == 0);
            pace_sender();
        end
        for (int i = 0; i < 9; i++) begin
            send_pixel(8'd255, i == 0);
            pace_sender();
        end

        // No columns, then no rows: a frame end reports nothing but still
        // clears, so the next full grid starts from zero counts.
        configure(3, 2, 0, 3, 1, 1, 0);
        send_frame(board.pixels_per_frame(), 70, 1, 0);
        configure(3, 2, 2, 0, 1, 1, 0);
        send_frame(board.pixels_per_frame(), 70, 1, 0);
        settle();
        program_reg(CFG_GRID_ROWS, 2);
        send_frame(board.pixels_per_frame(), 70, 1, 0);

        // Grid sides above the maximum are capped to an 8x8 grid.
        configure(9, 8, 15, 9, 1, 1, 17);
        send_frame(board.pixels_per_frame(), 60, 1, 0);

        // Zero cell width, then zero cell height: cells report zero counts.
        configure(4, 3, 2, 2, 0, 1, 33);
        send_frame(board.pixels_per_frame(), 80, 1, 0);
        configure(4, 3, 2, 2, 1, 0, 33);
        send_frame(board.pixels_per_frame(), 80, 1, 0);

        // Zero frame size acts as a one-pixel frame.
        configure(0, 0, 1, 1, 1, 1, 128);
        for (int i = 0; i < 4; i++)
            send_frame(1, 50, i[0], 0);

        // Cells that reach past the right and bottom edges of the frame.
        configure(5, 3, 3, 2, 2, 2, 200);
        send_frame(board.pixels_per_frame(), 60, 1, 0);
        send_frame(board.pixels_per_frame(), 60, 1, 0);

        // Settings changed part way through a frame. The cell right of the
        // first column stops being reported, but its count still feeds the
        // largest count.
        configure(4, 4, 2, 2, 2, 2, 7);
        send_frame(6, 100, 1, 0);
        settle();
        program_reg(CFG_GRID_COLUMNS, 1);
        program_reg(CFG_CELL_WIDTH, 1);
        send_frame(10, 30, 0, 0);

        // Back-pressure: the receiver holds off on the first report while
        // four frames of sixteen cells are pushed behind it.
        configure(4, 4, 4, 4, 1, 1, 99);
        hold_armed = 1'b1;
        for (int i = 0; i < 4; i++)
            send_frame(board.pixels_per_frame(), 50, 1, 0);

        // Cells far larger than the frame, with every bit of the cell height
        // set: every pixel falls in the first cell.
        configure(6, 2, 2, 2, 4096, 8191, 85);
        send_frame(board.pixels_per_frame(), 75, 1, 0);

        // Random part: mostly well-formed frames under random small settings,
        // with some truncated frames, unmarked starts and stray frame starts.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       width = 0;
                1:       width = $urandom_range(9, 12);
                default: width = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       height = 0;
                1:       height = $urandom_range(9, 12);
                default: height = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 11))
                0:       cols = 0;
                1:       cols = $urandom_range(9, 15);
                default: cols = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 11))
                0:       rows = 0;
                1:       rows = $urandom_range(9, 15);
                default: rows = $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 7))
                0:       cw = 0;
                1:       cw = $urandom_range(1, 5);
                default: cw = board.extent(CFG_W'(width)) / (cols == 0 ? 1 : board.side(GRID_W'(cols)));
            endcase
            case ($urandom_range(0, 7))
                0:       ch = 0;
                1:       ch = $urandom_range(1, 5);
                default: ch = board.extent(CFG_W'(height)) / (rows == 0 ? 1 : board.side(GRID_W'(rows)));
            endcase
            if (cw == 0 && $urandom_range(0, 1) == 0)
                cw = 1;
            if (ch == 0 && $urandom_range(0, 1) == 0)
                ch = 1;
            configure(width, height, cols, rows, cw, ch, $urandom_range(0, 255));

            frames = $urandom_range(1, 3);
            pct = $urandom_range(20, 90);
            for (int f = 0; f < frames; f++) begin
                pixels = board.pixels_per_frame();
                if ($urandom_range(0, 7) == 0)
                    pixels = $urandom_range(1, pixels);
                send_frame(pixels, pct, $urandom_range(0, 7) != 0, 1);
                random_items += pixels;
            end
        end

        settle();
        if (board.failures == 0 && board.pending() == 0)
            $display("** grid_zone_pixel_count: PASSED **");
        else
            $display("** grid_zone_pixel_count: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
